>>> sv/mat_pkg.sv
package mat_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam logic [7:0] LIMIT_RESET = 8'd5;

  localparam logic [1:0] OP_REGISTER   = 2'd0;
  localparam logic [1:0] OP_CONNECT    = 2'd1;
  localparam logic [1:0] OP_DISCONNECT = 2'd2;

  localparam logic [3:0] ST_REGISTERED    = 4'd0;
  localparam logic [3:0] ST_FULL          = 4'd1;
  localparam logic [3:0] ST_DUPLICATE     = 4'd2;
  localparam logic [3:0] ST_GRANTED       = 4'd3;
  localparam logic [3:0] ST_ALREADY       = 4'd4;
  localparam logic [3:0] ST_UNAUTHORIZED  = 4'd5;
  localparam logic [3:0] ST_LIMIT         = 4'd6;
  localparam logic [3:0] ST_UNKNOWN       = 4'd7;
  localparam logic [3:0] ST_DISCONNECTED  = 4'd8;
  localparam logic [3:0] ST_NOT_CONNECTED = 4'd9;
  localparam logic [3:0] ST_NOT_FOUND     = 4'd10;

  typedef struct packed {
    logic [1:0]  operation;
    logic [47:0] mac_address;
    logic [31:0] ip_address;
    logic        is_authorized;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
  } in_item_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] active_count;
    logic [7:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] ip;
    logic        authorized;
    logic        connected;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic exec;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ctl_sts_t;

endpackage

>>> sv/mat_ram.sv
module mat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_data <= mem[addr];
  end

endmodule

>>> sv/mat_ctrl.sv
module mat_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mat_pkg::ctl_sts_t sts,
  output mat_pkg::ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EXEC = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign cmd.load = (state_r == S_IDLE) && in_valid;
  assign cmd.scan = (state_r == S_SCAN);
  assign cmd.exec = (state_r == S_EXEC);
  assign cmd.emit = (state_r == S_OUT) && sts.out_free;

endmodule

>>> sv/mat_dpath.sv
module mat_dpath #(
  parameter int TABLE_DEPTH = mat_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mat_pkg::ctl_cmd_t  cmd,
  output mat_pkg::ctl_sts_t  sts,
  input  mat_pkg::in_item_t  in_data,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               out_stall,
  output logic               out_valid,
  output mat_pkg::out_item_t out_data
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;
  localparam int EW   = $bits(mat_pkg::entry_t);

  mat_pkg::in_item_t  item_r;
  mat_pkg::entry_t    rd_entry;
  mat_pkg::entry_t    hit_entry_r;
  mat_pkg::entry_t    wr_entry;
  mat_pkg::out_item_t out_r;
  logic [EW-1:0]      rd_word;

  logic [7:0]    limit_r;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] active_r, active_nxt;
  logic [CW-1:0] scan_idx_r;
  logic          pend_r;
  logic [AW-1:0] pend_idx_r;
  logic          hit_r;
  logic [AW-1:0] hit_idx_r;
  logic [3:0]    status_r, status_nxt;
  logic          out_valid_r;

  logic          full;
  logic          need_scan;
  logic          issue;
  logic          found;
  logic          ram_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] ram_addr;
  logic [CMPW-1:0] used_ext, active_ext, limit_ext;

  assign used_ext   = CMPW'(used_r);
  assign active_ext = CMPW'(active_r);
  assign limit_ext  = CMPW'(limit_r);

  assign full = (used_r >= CW'(TABLE_DEPTH));
  assign need_scan = (item_r.operation == mat_pkg::OP_CONNECT) ||
                     (item_r.operation == mat_pkg::OP_DISCONNECT) ||
                     ((item_r.operation == mat_pkg::OP_REGISTER) && !full);

  // Reads are pipelined one entry a cycle; the compare looks at the entry
  // issued in the previous cycle.
  assign issue = cmd.scan && need_scan && (scan_idx_r < used_r);
  assign rd_entry = mat_pkg::entry_t'(rd_word);
  assign found = cmd.scan && need_scan && pend_r && !hit_r &&
                 (rd_entry.mac == item_r.mac_address);

  assign sts.scan_done = !need_scan || hit_r || found || (scan_idx_r >= used_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (issue) begin
      pend_idx_r <= scan_idx_r[AW-1:0];
    end
    if (found) begin
      hit_idx_r   <= pend_idx_r;
      hit_entry_r <= rd_entry;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
    end
    if (cmd.emit) begin
      out_r.status       <= status_r;
      out_r.active_count <= active_ext[7:0];
      out_r.entry_count  <= used_ext[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= mat_pkg::LIMIT_RESET;
      used_r      <= '0;
      active_r    <= '0;
      scan_idx_r  <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      used_r   <= used_nxt;
      active_r <= active_nxt;
      if (cmd.load) begin
        scan_idx_r <= '0;
        hit_r      <= 1'b0;
      end else begin
        if (issue) begin
          scan_idx_r <= scan_idx_r + CW'(1);
        end
        if (found) begin
          hit_r <= 1'b1;
        end
      end
      pend_r <= issue;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    status_nxt = mat_pkg::ST_NOT_FOUND;
    used_nxt   = used_r;
    active_nxt = active_r;
    ram_we     = 1'b0;
    wr_addr    = hit_idx_r;
    wr_entry   = hit_entry_r;
    if (cmd.exec) begin
      case (item_r.operation)
        mat_pkg::OP_REGISTER: begin
          if (full) begin
            status_nxt = mat_pkg::ST_FULL;
          end else if (hit_r) begin
            status_nxt = mat_pkg::ST_DUPLICATE;
          end else begin
            status_nxt          = mat_pkg::ST_REGISTERED;
            ram_we              = 1'b1;
            wr_addr             = used_r[AW-1:0];
            wr_entry.mac        = item_r.mac_address;
            wr_entry.ip         = item_r.ip_address;
            wr_entry.authorized = item_r.is_authorized;
            wr_entry.connected  = 1'b0;
            wr_entry.hour       = '0;
            wr_entry.minute     = '0;
            used_nxt            = used_r + CW'(1);
          end
        end
        mat_pkg::OP_CONNECT: begin
          if (!hit_r) begin
            status_nxt = mat_pkg::ST_UNKNOWN;
          end else if (hit_entry_r.connected) begin
            status_nxt = mat_pkg::ST_ALREADY;
          end else if (!hit_entry_r.authorized) begin
            status_nxt = mat_pkg::ST_UNAUTHORIZED;
          end else if (active_ext >= limit_ext) begin
            status_nxt = mat_pkg::ST_LIMIT;
          end else begin
            status_nxt         = mat_pkg::ST_GRANTED;
            ram_we             = 1'b1;
            wr_entry.connected = 1'b1;
            wr_entry.hour      = item_r.now_hour;
            wr_entry.minute    = item_r.now_minute;
            active_nxt         = active_r + CW'(1);
          end
        end
        mat_pkg::OP_DISCONNECT: begin
          if (!hit_r) begin
            status_nxt = mat_pkg::ST_NOT_FOUND;
          end else if (!hit_entry_r.connected) begin
            status_nxt = mat_pkg::ST_NOT_CONNECTED;
          end else begin
            status_nxt         = mat_pkg::ST_DISCONNECTED;
            ram_we             = 1'b1;
            wr_entry.connected = 1'b0;
            if (active_r != '0) begin
              active_nxt = active_r - CW'(1);
            end
          end
        end
        default: begin
          status_nxt = mat_pkg::ST_NOT_FOUND;
        end
      endcase
    end
  end

  assign ram_addr = cmd.exec ? wr_addr : scan_idx_r[AW-1:0];

  mat_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_we),
    .addr   (ram_addr),
    .wr_data(EW'(wr_entry)),
    .rd_data(rd_word)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_active_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    active_r <= used_r)
    else $error("more connected devices than registered ones");

  a_used_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    hit_r |-> (CW'(hit_idx_r) < used_r))
    else $error("lookup hit outside the used entries");

  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !(cmd.scan || cmd.load))
    else $error("table write collides with a lookup");
`endif

endmodule

>>> sv/mac_admission_table_unit.sv
// Admission table for registered MAC addresses. Each transaction carries a
// register, connect or disconnect request and yields exactly one result with a
// status code, the connected-device count and the registered-device count.
// Requests are handled one at a time: a lookup reads the single-port table
// memory one entry per cycle and ends early when the key is found, while a
// register request on a full table, or an unused operation code, skips the
// lookup.
// A finished result waits in an output register, so the next transaction can
// be accepted while it is held. The connection limit resets to 5 and should
// only be written while no transaction is in flight.
module mac_admission_table_unit #(
  parameter int TABLE_DEPTH = mat_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mat_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mat_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  mat_pkg::ctl_cmd_t cmd;
  mat_pkg::ctl_sts_t sts;

  mat_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  mat_dpath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_data    (in_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule
